// ===== src/acdfa_pkg.sv =====
// Shared types and constants for the Aho-Corasick DFA scanner.
// Used by the controller, the datapath, the top level and the testbench; no dependencies.
package acdfa_pkg;

	localparam int NUM_STATES = 1024;
	localparam int STATE_W    = 10;
	localparam int ALPHABET   = 256;

	localparam logic [1:0] MODE_TRANS = 2'd0;
	localparam logic [1:0] MODE_ATTR  = 2'd1;
	localparam logic [1:0] MODE_SCAN  = 2'd2;

	localparam logic [1:0] OUT_NONE  = 2'd0;
	localparam logic [1:0] OUT_MATCH = 2'd1;
	localparam logic [1:0] OUT_NUL   = 2'd2;

	localparam logic [7:0] HIGH_BYTE = 8'd128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RD_NXT,
		ST_CHK,
		ST_WALK,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;   // capture input item
		logic load;   // write the table selected by the item's mode
		logic early;  // apply a scan byte decided without table reads
		logic rd_nxt; // latch transition target and previous state's attributes
		logic chk;    // decide on the new state's attributes
		logic walk;   // check one fail-chain state
		logic post;   // move the finished result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_scan;
		logic is_load;
		logic early;     // scan byte decided without table reads
		logic early_out; // early case produces a result
		logic reread;    // new state fell back to 0, read its attributes
		logic more;      // fail chain continues
		logic res;       // finished step produces a result
	} sts_t;

endpackage

// ===== src/acdfa_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module acdfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/acdfa_ctrl.sv =====
// Controller state machine for the scanner.
// Depends on acdfa_pkg.
module acdfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  acdfa_pkg::sts_t   sts,
	output acdfa_pkg::cmd_t   cmd
);
	acdfa_pkg::state_t state_q, state_d;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acdfa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.post | (out_valid_q & ~out_ready);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			acdfa_pkg::ST_IDLE: begin
				if (in_valid) state_d = acdfa_pkg::ST_DECODE;
			end
			acdfa_pkg::ST_DECODE: begin
				priority if (sts.is_scan && !sts.early) state_d = acdfa_pkg::ST_RD_NXT;
				else if (sts.is_scan && sts.early_out) state_d = acdfa_pkg::ST_OUT;
				else state_d = acdfa_pkg::ST_IDLE;
			end
			acdfa_pkg::ST_RD_NXT: state_d = acdfa_pkg::ST_CHK;
			acdfa_pkg::ST_CHK: begin
				priority if (sts.reread) state_d = acdfa_pkg::ST_CHK;
				else if (sts.more) state_d = acdfa_pkg::ST_WALK;
				else if (sts.res) state_d = acdfa_pkg::ST_OUT;
				else state_d = acdfa_pkg::ST_IDLE;
			end
			acdfa_pkg::ST_WALK: begin
				priority if (sts.more) state_d = acdfa_pkg::ST_WALK;
				else if (sts.res) state_d = acdfa_pkg::ST_OUT;
				else state_d = acdfa_pkg::ST_IDLE;
			end
			acdfa_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = acdfa_pkg::ST_IDLE;
			end
			default: state_d = acdfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			acdfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			acdfa_pkg::ST_DECODE: begin
				cmd.load = sts.is_load;
				cmd.early = sts.is_scan & sts.early;
			end
			acdfa_pkg::ST_RD_NXT: cmd.rd_nxt = 1'b1;
			acdfa_pkg::ST_CHK: cmd.chk = 1'b1;
			acdfa_pkg::ST_WALK: cmd.walk = 1'b1;
			// hold the result until the output register is free
			acdfa_pkg::ST_OUT: cmd.post = ~out_valid_q | out_ready;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// ===== src/acdfa_dp.sv =====
// Datapath for the scanner: tables, scan state, fail walk and result registers.
// Depends on acdfa_pkg and acdfa_ram.
module acdfa_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  acdfa_pkg::cmd_t cmd,
	output acdfa_pkg::sts_t sts,
	input  logic [1:0]      mode,
	input  logic [9:0]      state_index,
	input  logic [7:0]      byte_value,
	input  logic [9:0]      next_state,
	input  logic [9:0]      fail_link,
	input  logic            virtual_mark,
	input  logic            match_here,
	input  logic [9:0]      site_code,
	input  logic            last_byte,
	output logic [1:0]      outcome,
	output logic [9:0]      found_code
);
	localparam int SW = acdfa_pkg::STATE_W;
	localparam int AW = SW + 12; // fail, virtual, match valid, code

	// captured item
	logic [1:0]  mode_q;
	logic [9:0]  idx_q, nxt_in_q, fail_in_q, code_in_q;
	logic [7:0]  byte_q;
	logic        virt_in_q, match_in_q, last_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode;
			idx_q <= state_index;
			byte_q <= byte_value;
			nxt_in_q <= next_state;
			fail_in_q <= fail_link;
			virt_in_q <= virtual_mark;
			match_in_q <= match_here;
			code_in_q <= site_code;
			last_q <= last_byte;
		end
	end

	// scan state
	logic [SW-1:0] cur_q;
	logic          skip_q, done_q;

	// step registers
	logic          pv_q;
	logic [SW-1:0] nxt_q;
	logic [SW-1:0] cnt_q;
	logic [1:0]    out_q, outcome_q;
	logic [9:0]    code_q, found_code_q;

	// transition RAM
	logic [SW+7:0] t_waddr, t_raddr;
	logic [SW-1:0] t_rd;
	logic          t_we;
	assign t_we = cmd.load & (mode_q == acdfa_pkg::MODE_TRANS);
	assign t_waddr = {idx_q, byte_q};
	assign t_raddr = {cur_q, byte_q};
	acdfa_ram #(.WIDTH(SW), .DEPTH(acdfa_pkg::NUM_STATES * acdfa_pkg::ALPHABET)) u_trans (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(nxt_in_q),
		.raddr(t_raddr), .rdata(t_rd)
	);

	// attribute RAM
	logic [SW-1:0] a_raddr;
	logic [AW-1:0] a_rd, a_wdata;
	logic          a_we;
	assign a_we = cmd.load & (mode_q == acdfa_pkg::MODE_ATTR);
	assign a_wdata = {fail_in_q, virt_in_q, match_in_q, code_in_q};
	acdfa_ram #(.WIDTH(AW), .DEPTH(acdfa_pkg::NUM_STATES)) u_attr (
		.clk(clk), .we(a_we), .waddr(idx_q), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rd)
	);

	logic [SW-1:0] a_fail;
	logic          a_virt, a_mv;
	logic [9:0]    a_code;
	assign a_fail = a_rd[AW-1 -: SW];
	assign a_virt = a_rd[11];
	assign a_mv = a_rd[10];
	assign a_code = a_rd[9:0];

	logic is_high, nul;
	assign is_high = byte_q >= acdfa_pkg::HIGH_BYTE;
	assign nul = byte_q == 8'd0;

	// decisions on early cases, the new state and the fail chain
	logic early, early_out;
	logic force_zero, skip_c, hit_c, hit_w, hit, fail_nz;
	logic chk_more, walk_more, fin;
	assign early = done_q | skip_q | nul;
	assign early_out = ~done_q & (skip_q ? last_q : nul);
	// a virtual-to-virtual step on a high byte falls back to state 0
	assign force_zero = is_high & pv_q & a_virt & (nxt_q != '0);
	assign skip_c = is_high & (nxt_q == '0) & ~pv_q;
	assign hit_c = a_mv & (~is_high | pv_q) & ~skip_c;
	assign hit_w = a_mv & ~a_virt;
	assign fail_nz = a_fail != '0;
	assign chk_more = ~force_zero & ~skip_c & ~hit_c & fail_nz;
	assign walk_more = ~hit_w & fail_nz & (cnt_q != SW'(acdfa_pkg::NUM_STATES - 1));
	assign hit = cmd.walk ? hit_w : hit_c;
	assign fin = (cmd.chk & ~force_zero & ~chk_more) | (cmd.walk & ~walk_more);

	always_comb begin
		priority if (cmd.rd_nxt) a_raddr = t_rd;
		else if (cmd.chk && force_zero) a_raddr = '0;
		else if (cmd.chk || cmd.walk) a_raddr = a_fail;
		else a_raddr = cur_q;
	end

	assign sts.is_scan = mode_q == acdfa_pkg::MODE_SCAN;
	assign sts.is_load = (mode_q == acdfa_pkg::MODE_TRANS) | (mode_q == acdfa_pkg::MODE_ATTR);
	assign sts.early = early;
	assign sts.early_out = early_out;
	assign sts.reread = force_zero;
	assign sts.more = cmd.walk ? walk_more : chk_more;
	assign sts.res = hit | last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			skip_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.early || fin) begin
			if (last_q) begin
				cur_q <= '0;
				skip_q <= 1'b0;
				done_q <= 1'b0;
			end else if (cmd.early) begin
				skip_q <= 1'b0;
				if (!skip_q && !done_q) done_q <= 1'b1;
			end else begin
				cur_q <= nxt_q;
				if (hit) done_q <= 1'b1;
				if (cmd.chk && skip_c) skip_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_nxt) begin
			pv_q <= a_virt;
			nxt_q <= t_rd;
		end
		if (cmd.chk && force_zero) nxt_q <= '0;
		if (cmd.chk && chk_more) cnt_q <= '0;
		if (cmd.walk) cnt_q <= cnt_q + 1'b1;
		if (cmd.early) begin
			out_q <= skip_q ? acdfa_pkg::OUT_NONE : acdfa_pkg::OUT_NUL;
			code_q <= '0;
		end
		if (fin) begin
			out_q <= hit ? acdfa_pkg::OUT_MATCH : acdfa_pkg::OUT_NONE;
			code_q <= hit ? a_code : 10'd0;
		end
		if (cmd.post) begin
			outcome_q <= out_q;
			found_code_q <= code_q;
		end
	end

	assign outcome = outcome_q;
	assign found_code = found_code_q;
endmodule

// ===== src/aho_corasick_dfa_scanner_unit.sv =====
// Channel | Fields                                              | Handshake
// in      | mode state_index byte_value next_state fail_link    | in_valid/in_ready
//         | virtual_mark match_here site_code last_byte         |
// out     | outcome found_code                                  | out_valid/out_ready
// Load items and scan bytes decided without table reads are captured and decoded, then
// any result is posted; other scan bytes add a transition read, an attribute read and a
// decision, a reread when a virtual step falls back to state 0, a fail-chain walk and a
// result post. A waiting result stalls input only while the next result must post.
// Reset clears scan state and the output valid; tables are undefined until written.
// Depends on acdfa_pkg, acdfa_ctrl, acdfa_dp.
module aho_corasick_dfa_scanner_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [9:0] state_index,
	input  logic [7:0] byte_value,
	input  logic [9:0] next_state,
	input  logic [9:0] fail_link,
	input  logic       virtual_mark,
	input  logic       match_here,
	input  logic [9:0] site_code,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] outcome,
	output logic [9:0] found_code
);
	acdfa_pkg::cmd_t cmd;
	acdfa_pkg::sts_t sts;

	acdfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	acdfa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .state_index(state_index), .byte_value(byte_value),
		.next_state(next_state), .fail_link(fail_link),
		.virtual_mark(virtual_mark), .match_here(match_here),
		.site_code(site_code), .last_byte(last_byte),
		.outcome(outcome), .found_code(found_code)
	);
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for aho_corasick_dfa_scanner_unit: loads a small automaton,
// scans random buffers through it and compares results against a behavioral predictor.
// Depends on acdfa_pkg and the scanner RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam int N_STATES = acdfa_pkg::NUM_STATES;
	localparam int N_USED = 17;
	localparam int RANDOM_ITEMS = 250;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct {
		logic [1:0] mode;
		logic [9:0] idx;
		logic [7:0] b;
		logic [9:0] ns;
		logic [9:0] fl;
		logic       vm;
		logic       mh;
		logic [9:0] sc;
		logic       last;
	} in_item_t;

	typedef struct {
		logic [1:0] outcome;
		logic [9:0] code;
	} match_result_t;

	class match_scoreboard;
		logic [9:0] trans [N_STATES*256];
		bit         trans_known [N_STATES*256];
		logic [9:0] fail_of [N_STATES];
		logic       virt [N_STATES];
		logic       has_m [N_STATES];
		logic [9:0] code_of [N_STATES];
		logic [9:0] cur;
		bit         skip;
		bit         done;
		match_result_t pending [$];
		int         errors;

		function new();
			cur = '0;
			skip = 1'b0;
			done = 1'b0;
			errors = 0;
		endfunction

		function bit walk_fail(logic [9:0] s, output logic [9:0] code);
			logic [9:0] f;
			f = fail_of[s];
			for (int k = 0; k < N_STATES && f != 0; k++) begin
				if (has_m[f] && !virt[f]) begin
					code = code_of[f];
					return 1'b1;
				end
				f = fail_of[f];
			end
			return 1'b0;
		endfunction

		function void push(logic [1:0] oc, logic [9:0] code, bit last);
			match_result_t r;
			r.outcome = oc;
			r.code = code;
			pending.push_back(r);
			if (last) begin
				cur = '0;
				skip = 1'b0;
				done = 1'b0;
			end else begin
				done = 1'b1;
			end
		endfunction

		function void note(in_item_t it);
			logic [9:0] prev, nxt, code;
			bit found;
			found = 1'b0;
			code = '0;
			case (it.mode)
				acdfa_pkg::MODE_TRANS: begin
					trans[{it.idx, it.b}] = it.ns;
					trans_known[{it.idx, it.b}] = 1'b1;
				end
				acdfa_pkg::MODE_ATTR: begin
					fail_of[it.idx] = it.fl;
					virt[it.idx] = it.vm;
					has_m[it.idx] = it.mh;
					code_of[it.idx] = it.sc;
				end
				acdfa_pkg::MODE_SCAN: begin
					if (done) begin
						if (it.last) begin
							cur = '0;
							skip = 1'b0;
							done = 1'b0;
						end
					end else if (skip) begin
						skip = 1'b0;
						if (it.last) push(acdfa_pkg::OUT_NONE, '0, 1'b1);
					end else if (it.b == 0) begin
						push(acdfa_pkg::OUT_NUL, '0, it.last);
					end else begin
						prev = cur;
						nxt = trans[{prev, it.b}];
						if (it.b < acdfa_pkg::HIGH_BYTE) begin
							if (has_m[nxt]) begin
								found = 1'b1;
								code = code_of[nxt];
							end else begin
								found = walk_fail(nxt, code);
							end
						end else begin
							if (virt[prev] && virt[nxt]) nxt = '0;
							if (nxt == 0 && !virt[prev]) begin
								skip = 1'b1;
							end else if (has_m[nxt] && virt[prev]) begin
								found = 1'b1;
								code = code_of[nxt];
							end else begin
								found = walk_fail(nxt, code);
							end
						end
						cur = nxt;
						if (found) push(acdfa_pkg::OUT_MATCH, code, it.last);
						else if (it.last) push(acdfa_pkg::OUT_NONE, '0, 1'b1);
					end
				end
				default: ;
			endcase
		endfunction

		function void check(logic [1:0] oc, logic [9:0] code);
			match_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result outcome=%0d code=%0d", oc, code);
				return;
			end
			e = pending.pop_front();
			if (e.outcome !== oc || e.code !== code) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected outcome=%0d code=%0d, got outcome=%0d code=%0d",
						e.outcome, e.code, oc, code);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] mode;
	logic [9:0] state_index;
	logic [7:0] byte_value;
	logic [9:0] next_state;
	logic [9:0] fail_link;
	logic       virtual_mark;
	logic       match_here;
	logic [9:0] site_code;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] outcome;
	logic [9:0] found_code;

	aho_corasick_dfa_scanner_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .state_index(state_index), .byte_value(byte_value),
		.next_state(next_state), .fail_link(fail_link), .virtual_mark(virtual_mark),
		.match_here(match_here), .site_code(site_code), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.outcome(outcome), .found_code(found_code)
	);

	match_scoreboard sb = new();
	logic [9:0] used_states [N_USED];
	bit burst;
	int cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL aho_corasick_dfa_scanner_unit");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check(outcome, found_code);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [9:0] pick_state();
		return used_states[$urandom_range(0, N_USED - 1)];
	endfunction

	function automatic in_item_t noise_item(logic [1:0] m);
		in_item_t it;
		it.mode = m;
		it.idx = 10'($urandom);
		it.b = 8'($urandom);
		it.ns = 10'($urandom);
		it.fl = 10'($urandom);
		it.vm = 1'($urandom);
		it.mh = 1'($urandom);
		it.sc = 10'($urandom_range(0, 999));
		it.last = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t attr_item(logic [9:0] s);
		in_item_t it;
		it = noise_item(acdfa_pkg::MODE_ATTR);
		it.idx = s;
		it.fl = pick_state();
		return it;
	endfunction

	function automatic in_item_t trans_item(logic [9:0] s, logic [7:0] b);
		in_item_t it;
		it = noise_item(acdfa_pkg::MODE_TRANS);
		it.idx = s;
		it.b = b;
		it.ns = pick_state();
		return it;
	endfunction

	// Try to choose a byte whose transition from the current state is loaded, unless the byte
	// will not be examined at all; sometimes pick NUL, and fall back to a fixed byte after 30 misses.
	function automatic in_item_t scan_item(bit last);
		in_item_t it;
		logic [7:0] fixed [4] = '{8'd1, 8'd127, 8'd128, 8'd255};
		it = noise_item(acdfa_pkg::MODE_SCAN);
		it.last = last;
		if (sb.done || sb.skip) return it;
		if ($urandom_range(0, 19) == 0) begin
			it.b = '0;
			return it;
		end
		for (int k = 0; k < 30; k++) begin
			it.b = 8'($urandom_range(1, 255));
			if (sb.trans_known[{sb.cur, it.b}]) return it;
		end
		it.b = fixed[$urandom_range(0, 3)];
		return it;
	endfunction

	task automatic send(in_item_t it);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g > 0) begin
			in_valid = 0;
			repeat (g) @(negedge clk);
		end
		mode = it.mode;
		state_index = it.idx;
		byte_value = it.b;
		next_state = it.ns;
		fail_link = it.fl;
		virtual_mark = it.vm;
		match_here = it.mh;
		site_code = it.sc;
		last_byte = it.last;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note(it);
	endtask

	initial begin
		int stall;
		stall = 0;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 0;
				stall--;
			end else begin
				out_ready = 1;
				if ($urandom_range(0, 3) == 0) stall = gap_len();
			end
		end
	end

	initial begin
		in_item_t it;
		logic [7:0] fixed [4];
		int r;
		fixed = '{8'd1, 8'd127, 8'd128, 8'd255};
		burst = 0;
		arst_n = 0;
		in_valid = 0;
		mode = acdfa_pkg::MODE_TRANS;
		state_index = '0;
		byte_value = '0;
		next_state = '0;
		fail_link = '0;
		virtual_mark = 0;
		match_here = 0;
		site_code = '0;
		last_byte = 0;
		for (int i = 0; i < N_USED - 1; i++) used_states[i] = 10'(i);
		used_states[N_USED - 1] = 10'd1023;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// load the automaton; the top state is a virtual self-looping fail chain
		for (int i = 0; i < N_USED; i++) send(attr_item(used_states[i]));
		it = attr_item(10'd1023);
		it.fl = 10'd1023;
		it.vm = 1;
		it.mh = 1;
		it.sc = 10'd999;
		send(it);
		it = attr_item(10'd0);
		it.mh = 1;
		it.sc = '0;
		send(it);
		for (int i = 0; i < N_USED; i++) begin
			for (int j = 0; j < 4; j++) send(trans_item(used_states[i], fixed[j]));
			for (int j = 0; j < 5; j++)
				send(trans_item(used_states[i], 8'($urandom_range(0, 255))));
		end
		it = trans_item(10'd0, 8'd1);
		it.ns = 10'd1023;
		send(it);

		// directed scans: byte extremes, NUL, skipped bytes, unused mode
		for (int j = 0; j < 4; j++) send(scan_item(1'b0));
		send(scan_item(1'b1));
		it = scan_item(1'b0);
		it.b = '0;
		send(it);
		send(scan_item(1'b0));
		send(scan_item(1'b1));
		it = scan_item(1'b0);
		it.b = 8'd1;
		send(it);
		for (int j = 0; j < 6; j++) send(scan_item(j == 5));
		send(noise_item(MODE_IGNORED));
		for (int j = 0; j < 6; j++) send(scan_item(j == 5));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 50) burst = 1;
			if (n % 100 == 80) burst = 0;
			r = $urandom_range(0, 99);
			if (r < 84) send(scan_item($urandom_range(0, 5) == 0));
			else if (r < 89) send(attr_item(pick_state()));
			else if (r < 96) send(trans_item(pick_state(), 8'($urandom_range(0, 255))));
			else send(noise_item(MODE_IGNORED));
		end

		@(negedge clk);
		in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS aho_corasick_dfa_scanner_unit");
		else
			$display("FAIL aho_corasick_dfa_scanner_unit");
		$finish;
	end
endmodule
